FILE: rtl/core/jsfx_pkg.sv
package jsfx_pkg;

  // default and hard limit for the key length
  localparam int MAX_KEY_BYTES_DEF = 8;
  localparam int KEY_LEN_MAX       = 15;
  localparam int KEY_TEXT_BYTES    = 8;

  // configuration port geometry
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 64;

  // characters the parser cares about
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_LO_N   = 8'h6e;
  localparam logic [7:0] CH_LO_R   = 8'h72;
  localparam logic [7:0] CH_LO_T   = 8'h74;
  localparam logic [7:0] CH_LO_B   = 8'h62;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_LO_U   = 8'h75;

  // register indexes on the configuration port
  typedef enum logic {
    REG_KEY_TEXT   = 1'b0,
    REG_KEY_LENGTH = 1'b1
  } reg_idx_t;

  // parser phase
  typedef enum logic [2:0] {
    PH_SEARCH = 3'd0,
    PH_COLON  = 3'd1,
    PH_QUOTE  = 3'd2,
    PH_VALUE  = 3'd3,
    PH_CLOSED = 3'd4,
    PH_BAD    = 3'd5
  } phase_t;

  // final status codes
  typedef enum logic [2:0] {
    ST_BUSY      = 3'd0,
    ST_CLOSED    = 3'd1,
    ST_UNTERM    = 3'd2,
    ST_NOKEY     = 3'd3,
    ST_MALFORMED = 3'd4
  } status_t;

  // output byte counts
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } jsfx_in_t;

  typedef struct packed {
    logic [7:0] first_out;
    logic [7:0] second_out;
    logic [1:0] out_count;
    logic       final_flag;
    logic [2:0] status;
  } jsfx_out_t;

  // key configuration handed from the register file to the parser
  typedef struct packed {
    logic [63:0] key_text;
    logic [3:0]  key_length;
  } jsfx_key_t;

endpackage

FILE: rtl/core/json_string_field_extractor.sv
// pipeline: the request sits in the input register, then one level of parser
// logic fills the result register; throughput: one byte per cycle unless
// out_stall holds the result register; the parser state updates once per byte
// reset: synchronous active-low rst_n clears both pipeline valids, the
// parser state (searching, no match, no escape) and the key registers
module json_string_field_extractor #(
  parameter int MAX_KEY_BYTES = jsfx_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  jsfx_pkg::jsfx_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output jsfx_pkg::jsfx_out_t              out_data,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [jsfx_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [jsfx_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [jsfx_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import jsfx_pkg::*;

  logic      in_vld_r;
  jsfx_in_t  in_item_r;
  logic      out_vld_r;
  jsfx_out_t out_item_r;
  jsfx_out_t result;
  jsfx_key_t key;
  logic      in_acc;
  logic      adv;

  jsfx_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .key     (key)
  );

  jsfx_core #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .item   (in_item_r),
    .key    (key),
    .result (result)
  );

  // handshake: the input register moves on whenever the result register is free
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_item_r <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  // input side stalls only with a request already held
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r && out_vld_r)
    else $error("input stalled with a free pipeline");

  // status is reported on the final result only
  a_status_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.final_flag |-> out_data.status == ST_BUSY)
    else $error("status on a non-final result");

  // two value bytes only for the u escape
  a_two_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_count == CNT_TWO |->
      out_data.first_out == CH_BSLASH && out_data.second_out == CH_LO_U)
    else $error("two value bytes outside a u escape");

endmodule

FILE: rtl/core/jsfx_cfg.sv
module jsfx_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [jsfx_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [jsfx_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [jsfx_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  output jsfx_pkg::jsfx_key_t              key
);
  import jsfx_pkg::*;

  logic [63:0] key_text_r;
  logic [3:0]  key_length_r;
  logic        wr_en;
  reg_idx_t    reg_idx;

  // registers sit on 8-byte boundaries
  assign reg_idx = reg_idx_t'(paddr[3]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_text_r   <= '0;
      key_length_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_KEY_TEXT:   key_text_r   <= pwdata[63:0];
        REG_KEY_LENGTH: key_length_r <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_KEY_TEXT:   prdata = key_text_r;
      REG_KEY_LENGTH: prdata = {{(CFG_DATA_W-4){1'b0}}, key_length_r};
      default:        prdata = '0;
    endcase
  end

  assign key.key_text   = key_text_r;
  assign key.key_length = key_length_r;

endmodule

FILE: rtl/core/jsfx_core.sv
module jsfx_core #(
  parameter int MAX_KEY_BYTES = jsfx_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  jsfx_pkg::jsfx_in_t   item,
  input  jsfx_pkg::jsfx_key_t  key,
  output jsfx_pkg::jsfx_out_t  result
);
  import jsfx_pkg::*;

  localparam int EFF_MAX = (MAX_KEY_BYTES < KEY_LEN_MAX) ? MAX_KEY_BYTES : KEY_LEN_MAX;
  localparam int POS_W   = $clog2(EFF_MAX + 3);

  logic [POS_W-1:0] pos_r, pos_nxt, pos_step, pos_cur, len;
  phase_t           phase_r, phase_nxt, phase_step;
  logic             esc_r, esc_nxt, esc_step;
  logic [7:0]       b;
  logic [7:0]       needle;
  logic             ws;

  function automatic logic [7:0] decode_esc(input logic [7:0] c);
    logic [7:0] d;
    unique case (c)
      CH_LO_N: d = CH_LF;
      CH_LO_R: d = CH_CR;
      CH_LO_T: d = CH_TAB;
      CH_LO_B: d = CH_BS;
      CH_LO_F: d = CH_FF;
      default: d = c;
    endcase
    return d;
  endfunction

  assign b  = item.data_byte;
  assign ws = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));

  // effective key length, clamped to the build limit
  assign len = (int'(key.key_length) > MAX_KEY_BYTES) ? POS_W'(MAX_KEY_BYTES)
                                                      : POS_W'(key.key_length);

  // stale match position after a key change restarts the search
  assign pos_cur = (int'(pos_r) > int'(len) + 1) ? '0 : pos_r;

  // needle byte: quote, key characters, quote
  always_comb begin
    needle = '0;
    if (pos_cur == '0 || int'(pos_cur) == int'(len) + 1) begin
      needle = CH_QUOTE;
    end else begin
      for (int k = 0; k < KEY_TEXT_BYTES; k++) begin
        if (int'(pos_cur) == k + 1) needle = key.key_text[8*k +: 8];
      end
    end
  end

  // next state for one byte
  always_comb begin
    pos_step   = pos_r;
    phase_step = phase_r;
    esc_step   = esc_r;
    unique case (phase_r)
      PH_SEARCH: begin
        if (b == needle) begin
          if (int'(pos_cur) + 1 == int'(len) + 2) begin
            phase_step = PH_COLON;
            pos_step   = '0;
          end else begin
            pos_step = pos_cur + 1'b1;
          end
        end else if (b == CH_QUOTE) begin
          pos_step = POS_W'(1);
        end else begin
          pos_step = '0;
        end
      end
      PH_COLON: begin
        if (b == CH_COLON) phase_step = PH_QUOTE;
        else if (!ws)      phase_step = PH_BAD;
      end
      PH_QUOTE: begin
        if (b == CH_QUOTE) phase_step = PH_VALUE;
        else if (!ws)      phase_step = PH_BAD;
      end
      PH_VALUE: begin
        if (esc_r)                 esc_step   = 1'b0;
        else if (b == CH_BSLASH)   esc_step   = 1'b1;
        else if (b == CH_QUOTE)    phase_step = PH_CLOSED;
      end
      PH_CLOSED: ;
      default:   phase_step = PH_BAD;
    endcase
  end

  // last byte rearms the parser
  always_comb begin
    if (item.last_byte) begin
      pos_nxt   = '0;
      phase_nxt = PH_SEARCH;
      esc_nxt   = 1'b0;
    end else begin
      pos_nxt   = pos_step;
      phase_nxt = phase_step;
      esc_nxt   = esc_step;
    end
  end

  // value bytes and final status
  always_comb begin
    result            = '0;
    result.final_flag = item.last_byte;
    if (phase_r == PH_VALUE) begin
      if (esc_r) begin
        if (b == CH_LO_U) begin
          result.first_out  = CH_BSLASH;
          result.second_out = CH_LO_U;
          result.out_count  = CNT_TWO;
        end else begin
          result.first_out = decode_esc(b);
          result.out_count = CNT_ONE;
        end
      end else if (b != CH_BSLASH && b != CH_QUOTE) begin
        result.first_out = b;
        result.out_count = CNT_ONE;
      end
    end
    if (item.last_byte) begin
      unique case (phase_step)
        PH_SEARCH: result.status = ST_NOKEY;
        PH_VALUE:  result.status = ST_UNTERM;
        PH_CLOSED: result.status = ST_CLOSED;
        default:   result.status = ST_MALFORMED;
      endcase
    end else begin
      result.status = ST_BUSY;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      phase_r <= PH_SEARCH;
      esc_r   <= 1'b0;
    end else if (en) begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      esc_r   <= esc_nxt;
    end
  end

  // a final byte always leaves the parser searching from scratch
  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    en && item.last_byte |=> phase_r == PH_SEARCH && pos_r == '0 && !esc_r)
    else $error("parser not rearmed after final byte");

  // match position only lives while searching
  a_pos_search: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_SEARCH |-> pos_r == '0)
    else $error("match position set outside search");

  // pending escape only inside the value
  a_esc_value: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> phase_r == PH_VALUE)
    else $error("escape pending outside value");

endmodule
